### design/bvl_pkg.sv
// Shared types and codes for the bounded value list.
package bvl_pkg;

   // Operation codes carried by req_opcode
   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // Status codes carried by rsp_status
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } stat_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_CLEAR,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DISP_RD,
      S_DISP_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic     load_item;  // capture the incoming value
      logic     idx_clr;    // reset the walk index
      logic     idx_inc;    // advance the walk index
      logic     rd_en;      // read the store
      logic     rd_next;    // read at index + 1 instead of index
      logic     wr_en;      // write the store
      logic     wr_shift;   // write read data at index, else item at tail
      logic     cnt_inc;
      logic     cnt_dec;
      logic     cnt_clr;
      logic     emit;       // load the result register
      logic     emit_val;   // result carries the read data
      logic     emit_last;
      stat_type emit_stat;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;       // count at capacity
      logic empty;      // count is zero
      logic match;      // read data equals the held item
      logic scan_end;   // index has reached the count
      logic idx_last;   // index is the last held position
      logic slot_free;  // result register can take a word this cycle
   } flags_type;

endpackage

### design/bounded_value_list.sv
// Top level of the bounded value list: controller, datapath and checks.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_opcode, req_item_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_value, rsp_status,
//           |           |                     | rsp_entry_count, rsp_last_result
//
// One word is worked on at a time; req_stall is high from acceptance until its
// last result is loaded into the output register. Append and clear finish in
// the state after acceptance; delete reads and compares each entry scanned,
// then reads and writes each entry shifted down; display reads each value and
// then outputs it. The value store's registered read sets these steps, and
// rsp_stall only holds results back. Reset is synchronous and empties the list; no clearing pass is needed.
module bounded_value_list #(
   parameter int LIST_DEPTH  = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_entry_count,
   output logic               rsp_last_result
);
   import bvl_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   bvl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .flags      (flags),
      .cmd        (cmd)
   );

   bvl_data #(
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_data (
      .clock           (clock),
      .reset           (reset),
      .req_item_value  (req_item_value),
      .cmd             (cmd),
      .flags           (flags),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last_result (rsp_last_result)
   );

   // A new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   // The store is written only while a word is in progress
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> req_stall)
      else $error("store written while idle");

   // A nonzero value appears only in a display result with status ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_value != 0) |-> (rsp_status == STAT_OK))
      else $error("value on a non-display result");

   // An empty report is final and shows a zero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_last_result && rsp_entry_count == 6'd0))
      else $error("bad empty report");

endmodule

### design/bvl_ctrl.sv
// Controller state machine for the bounded value list.
module bvl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_stall,
   input  bvl_pkg::flags_type  flags,
   output bvl_pkg::cmd_type    cmd
);
   import bvl_pkg::*;

   state_type state_ff;
   state_type state_in;
   op_type    opcode;

   assign opcode = op_type'(req_opcode);

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (opcode)
                  OP_APPEND:  state_in = S_APPEND;
                  OP_DELETE:  state_in = S_SCAN_RD;
                  OP_DISPLAY: state_in = S_DISP_RD;
                  OP_CLEAR:   state_in = S_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_APPEND, S_CLEAR: begin
            if (flags.slot_free) state_in = S_IDLE;
         end
         S_SCAN_RD: begin
            if (!flags.scan_end) state_in = S_SCAN_CMP;
            else if (flags.slot_free) state_in = S_IDLE;
         end
         S_SCAN_CMP: begin
            state_in = flags.match ? S_SHIFT_RD : S_SCAN_RD;
         end
         S_SHIFT_RD: begin
            if (!flags.idx_last) state_in = S_SHIFT_WR;
            else if (flags.slot_free) state_in = S_IDLE;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_DISP_RD: begin
            if (!flags.empty) state_in = S_DISP_OUT;
            else if (flags.slot_free) state_in = S_IDLE;
         end
         S_DISP_OUT: begin
            if (flags.slot_free) state_in = flags.idx_last ? S_IDLE : S_DISP_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.emit_stat = STAT_OK;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_item = req_valid;
            cmd.idx_clr   = req_valid;
         end
         S_APPEND: begin
            if (flags.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (flags.full) begin
                  cmd.emit_stat = STAT_FULL;
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         S_CLEAR: begin
            if (flags.slot_free) begin
               cmd.cnt_clr   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (!flags.scan_end) begin
               cmd.rd_en = 1'b1;
            end else if (flags.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_stat = STAT_NOT_FOUND;
            end
         end
         S_SCAN_CMP: begin
            cmd.idx_inc = !flags.match;
         end
         S_SHIFT_RD: begin
            if (!flags.idx_last) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
            end else if (flags.slot_free) begin
               cmd.cnt_dec   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         S_DISP_RD: begin
            if (!flags.empty) begin
               cmd.rd_en = 1'b1;
            end else if (flags.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_stat = STAT_EMPTY;
            end
         end
         S_DISP_OUT: begin
            if (flags.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_val  = 1'b1;
               cmd.emit_last = flags.idx_last;
               cmd.idx_inc   = !flags.idx_last;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/bvl_data.sv
// Datapath for the bounded value list: value store, count, walk index, result register.
module bvl_data #(
   parameter int LIST_DEPTH  = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [31:0]  req_item_value,
   input  bvl_pkg::cmd_type    cmd,
   output bvl_pkg::flags_type  flags,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_out_value,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_entry_count,
   output logic                rsp_last_result
);
   import bvl_pkg::*;

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [VALUE_WIDTH-1:0]        list_mem_ff [LIST_DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [VALUE_WIDTH-1:0]        item_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [CNT_W-1:0]              idx_ff;
   logic [CNT_W-1:0]              idx_in;
   logic [CNT_W:0]                idx_nx;
   logic [ADDR_W-1:0]             rd_addr;
   logic [ADDR_W-1:0]             wr_addr;
   logic [VALUE_WIDTH-1:0]        wr_data;
   logic signed [63:0]            in_wide;
   logic signed [63:0]            rd_wide;

   logic                          rsp_valid_ff;
   logic signed [31:0]            rsp_value_ff;
   logic [1:0]                    rsp_status_ff;
   logic [5:0]                    rsp_count_ff;
   logic                          rsp_last_ff;

   // Sign-extend both sides to 64 bits, then fit to the store or output width
   assign in_wide = 64'(req_item_value);
   assign rd_wide = 64'(rd_data_ff);

   assign idx_nx  = {1'b0, idx_ff} + 1'b1;
   assign rd_addr = cmd.rd_next ? idx_nx[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign wr_addr = cmd.wr_shift ? idx_ff[ADDR_W-1:0] : count_ff[ADDR_W-1:0];
   assign wr_data = cmd.wr_shift ? rd_data_ff : item_ff;

   // Status toward the controller
   assign flags.full      = (count_ff == CNT_W'(LIST_DEPTH));
   assign flags.empty     = (count_ff == '0);
   assign flags.match     = (rd_data_ff == item_ff);
   assign flags.scan_end  = (idx_ff >= count_ff);
   assign flags.idx_last  = (idx_nx >= {1'b0, count_ff});
   assign flags.slot_free = !rsp_valid_ff || !rsp_stall;

   // Value store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         list_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= list_mem_ff[rd_addr];
      end
   end

   // Hold the item of the current word
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= VALUE_WIDTH'(in_wide);
      end
   end

   // Count and walk index updates
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_nx[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Result register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff  <= cmd.emit_val ? rd_wide[31:0] : '0;
         rsp_status_ff <= cmd.emit_stat;
         rsp_count_ff  <= 6'(count_in);
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
